/* hw/rtl/lkdst_pkg.sv */
// Package for the LRU key distinct-source tracker.
// Holds shared widths, parameter defaults and reset values.
// No dependencies.
package lkdst_pkg;
   localparam int NumSlotsDefault   = 64;
   localparam int MaxSourcesDefault = 32;
   localparam int KeyW   = 64;
   localparam int SrcW   = 32;
   localparam int TimeW  = 63;
   localparam int CntW   = 6;
   localparam logic [CntW-1:0] ThreshReset = 6'd2;
   localparam logic [CntW-1:0] CountOutMax = 6'd63;
endpackage

/* hw/rtl/lkdst_srclist.sv */
// Per-slot source list memory with a sequential membership search.
// Depends on lkdst_pkg.
module lkdst_srclist #(
   parameter int NUM_SLOTS   = lkdst_pkg::NumSlotsDefault,
   parameter int MAX_SOURCES = lkdst_pkg::MaxSourcesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [$clog2(NUM_SLOTS)-1:0]  slot,
   input  logic [$clog2(MAX_SOURCES+1)-1:0] count,
   input  logic [lkdst_pkg::SrcW-1:0]    src,
   output logic                          done,
   output logic [$clog2(MAX_SOURCES+1)-1:0] new_count
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int NW = $clog2(MAX_SOURCES+1);
   localparam int AW = SW + IW;
   localparam logic [NW-1:0] MaxN = NW'(MAX_SOURCES);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK} state_type;

   logic [lkdst_pkg::SrcW-1:0] mem [NUM_SLOTS*(2**IW)];
   logic [lkdst_pkg::SrcW-1:0] rd_ff;
   state_type state_ff;
   logic [NW-1:0] idx_ff;
   logic done_ff;
   logic [NW-1:0] ncnt_ff;
   logic [AW-1:0] rd_addr;
   logic wr_en;

   assign rd_addr = {slot, idx_ff[IW-1:0]};
   assign wr_en = (state_ff == S_CHECK) && (idx_ff == count) && (count < MaxN);

   // Memory: registered read, single write
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) mem[rd_addr] <= src;
   end

   // Walk the list one entry at a time: address it in S_CHECK, compare it in S_READ
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
         ncnt_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  idx_ff   <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_READ: begin
               // compare the entry addressed in the last check cycle
               if (rd_ff == src) begin
                  ncnt_ff  <= count;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  done_ff  <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (idx_ff == count) begin
                  ncnt_ff  <= (count < MaxN) ? count + NW'(1) : count;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  done_ff  <= 1'b0;
                  state_ff <= S_READ;
                  idx_ff   <= idx_ff + NW'(1);
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign new_count = ncnt_ff;
endmodule

/* hw/rtl/lru_key_distinct_source_tracker_core.sv */
// LRU key distinct-source tracker top level.
// Uses lkdst_pkg and lkdst_srclist; holds the slot memories and scan FSM.
//
// Usage: present a transaction on req_* (key words, source id, now_ms) with
// req_valid; req_ready is high only while the block is idle and no csr_*
// write is offered. The block scans slots in memory (address, then compare
// for each slot) and stops at the matching slot, else picks the first free
// or least recently used slot, then walks that slot's source list one
// stored source at a time. One result per transaction appears on rsp_*
// with rsp_valid and holds until rsp_ready.
// One item at a time: the next request is taken only once the block is back
// in idle after the result transaction.
// Reset clears all slot valid bits (flip-flops) and sets the threshold to 2;
// no clearing pass is needed. A stalled receiver holds the result and
// blocks new requests. csr_* writes the escalation threshold at any time
// while idle.
module lru_key_distinct_source_tracker_core #(
   parameter int NUM_SLOTS   = lkdst_pkg::NumSlotsDefault,
   parameter int MAX_SOURCES = lkdst_pkg::MaxSourcesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_key_word0,
   input  logic [63:0] req_key_word1,
   input  logic [63:0] req_key_word2,
   input  logic [63:0] req_key_word3,
   input  logic [31:0] req_source_id,
   input  logic [62:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_distinct_count,
   output logic        rsp_first_escalate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_escalate_threshold
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int NW = $clog2(MAX_SOURCES+1);
   localparam logic [SW:0] NSlots = (SW+1)'(NUM_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE, S_ADDR, S_CMP, S_LIST, S_WAITL, S_OUT
   } state_type;

   // Slot memories: key 256 bits, time, count, escalated
   logic [255:0] key_mem [NUM_SLOTS];
   logic [62:0]  time_mem [NUM_SLOTS];
   logic [NW-1:0] cnt_mem [NUM_SLOTS];
   logic         esc_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;

   logic [255:0] key_rd_ff;
   logic [62:0]  time_rd_ff;
   logic [NW-1:0] cnt_rd_ff;
   logic         esc_rd_ff;

   state_type state_ff;
   logic [SW:0]  idx_ff;
   logic [SW-1:0] rd_addr;
   logic [255:0] key_ff;
   logic [31:0]  src_ff;
   logic [62:0]  now_ff;
   logic [5:0]   thresh_ff;
   logic         hit_ff, free_ff;
   logic [SW-1:0] hit_s_ff, free_s_ff, old_s_ff;
   logic [62:0]  old_t_ff;
   logic [SW-1:0] sel_s_ff;
   logic         claim_ff;
   logic [NW-1:0] base_cnt_ff;
   logic         base_esc_ff;
   logic         wb_en;
   logic [NW-1:0] wb_cnt;
   logic         wb_esc;
   logic         list_start;
   logic         list_done;
   logic [NW-1:0] list_cnt;
   logic [5:0]   out_cnt_ff;
   logic         out_esc_ff;
   logic         slot_v;
   logic [6:0]   full_n;

   assign slot_v  = valid_ff[idx_ff[SW-1:0]];
   assign rd_addr = (state_ff == S_LIST || state_ff == S_WAITL) ? sel_s_ff : idx_ff[SW-1:0];

   // Slot memory read port and write-back
   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[rd_addr];
      time_rd_ff <= time_mem[rd_addr];
      cnt_rd_ff  <= cnt_mem[rd_addr];
      esc_rd_ff  <= esc_mem[rd_addr];
      if (wb_en) begin
         key_mem[sel_s_ff]  <= key_ff;
         time_mem[sel_s_ff] <= now_ff;
         cnt_mem[sel_s_ff]  <= wb_cnt;
         esc_mem[sel_s_ff]  <= wb_esc;
      end
   end

   assign full_n = 7'(list_cnt);
   assign wb_en  = (state_ff == S_WAITL) && list_done;
   assign wb_cnt = list_cnt;
   assign wb_esc = base_esc_ff || (full_n >= 7'(thresh_ff));
   assign list_start = (state_ff == S_LIST);

   lkdst_srclist #(.NUM_SLOTS(NUM_SLOTS), .MAX_SOURCES(MAX_SOURCES)) u_list (
      .clock, .reset,
      .start(list_start),
      .slot(sel_s_ff),
      .count(base_cnt_ff),
      .src(src_ff),
      .done(list_done),
      .new_count(list_cnt)
   );

   // Scan, claim, list update and result hold
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         thresh_ff <= lkdst_pkg::ThreshReset;
         idx_ff    <= '0;
      end else begin
         if (csr_valid && state_ff == S_IDLE) thresh_ff <= csr_escalate_threshold;
         case (state_ff)
            S_IDLE: if (req_valid && !csr_valid) begin
               key_ff  <= {req_key_word3, req_key_word2, req_key_word1, req_key_word0};
               src_ff  <= req_source_id;
               now_ff  <= req_now_ms;
               hit_ff  <= 1'b0;
               free_ff <= 1'b0;
               old_s_ff <= '0;
               idx_ff  <= '0;
               state_ff <= S_ADDR;
            end
            S_ADDR: state_ff <= S_CMP;
            S_CMP: begin
               if (slot_v && key_rd_ff == key_ff && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_s_ff <= idx_ff[SW-1:0];
                  base_cnt_ff <= cnt_rd_ff;
                  base_esc_ff <= esc_rd_ff;
               end
               if (!slot_v && !free_ff) begin
                  free_ff <= 1'b1;
                  free_s_ff <= idx_ff[SW-1:0];
               end
               if (idx_ff == '0 || time_rd_ff < old_t_ff) begin
                  old_s_ff <= idx_ff[SW-1:0];
                  old_t_ff <= time_rd_ff;
               end
               if (idx_ff == NSlots - (SW+1)'(1) ||
                   (slot_v && key_rd_ff == key_ff)) begin
                  state_ff <= S_LIST;
                  if (slot_v && key_rd_ff == key_ff && !hit_ff) begin
                     sel_s_ff <= idx_ff[SW-1:0];
                  end else if (hit_ff) begin
                     sel_s_ff <= hit_s_ff;
                  end else begin
                     base_cnt_ff <= '0;
                     base_esc_ff <= 1'b0;
                     if (free_ff) sel_s_ff <= free_s_ff;
                     else if (!slot_v) sel_s_ff <= idx_ff[SW-1:0];
                     else if (time_rd_ff < old_t_ff) sel_s_ff <= idx_ff[SW-1:0];
                     else sel_s_ff <= old_s_ff;
                  end
               end else begin
                  idx_ff <= idx_ff + (SW+1)'(1);
                  state_ff <= S_ADDR;
               end
            end
            S_LIST: begin
               valid_ff[sel_s_ff] <= 1'b1;
               state_ff <= S_WAITL;
            end
            S_WAITL: if (list_done) begin
               out_cnt_ff <= (7'(list_cnt) > 7'(lkdst_pkg::CountOutMax)) ?
                             lkdst_pkg::CountOutMax : 6'(list_cnt);
               out_esc_ff <= !base_esc_ff && (full_n >= 7'(thresh_ff));
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_distinct_count = out_cnt_ff;
   assign rsp_first_escalate = out_esc_ff;

   // Result only follows a completed list walk
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(list_done)) else $error("result without list walk");
   // Count never exceeds list capacity
   assert property (@(posedge clock) disable iff (reset)
      list_done |=> 7'(list_cnt) <= 7'(MAX_SOURCES)) else $error("count overflow");
   // Claimed slot becomes valid
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |=> valid_ff[sel_s_ff]) else $error("slot not claimed");
endmodule
